// ----- src/bsc_pkg.sv -----
package bsc_pkg;

	localparam int unsigned DW = 32;

	localparam logic [2:0] REG_AC_FIRST  = 3'd0;
	localparam logic [2:0] REG_AC_SECOND = 3'd1;
	localparam logic [2:0] REG_B_PAIR    = 3'd2;
	localparam logic [2:0] REG_M_PAIR    = 3'd3;
	localparam logic [2:0] REG_OSS       = 3'd4;

	localparam logic [31:0] C_B6_OFFSET = 32'd4000;
	localparam logic [31:0] C_B4_BIAS   = 32'd32768;
	localparam logic [31:0] C_B7_SCALE  = 32'd50000;
	localparam logic [31:0] C_P_SQ      = 32'd3038;
	localparam logic [31:0] C_P_LIN     = 32'hFFFF_E343;
	localparam logic [31:0] C_P_OFFSET  = 32'd3791;

	typedef struct packed {
		logic        fault;
		logic        neg;
		logic        post;
		logic [31:0] up;
		logic [31:0] tmp;
		logic [31:0] x1;
		logic [31:0] b5;
		logic [31:0] b6;
		logic [31:0] sq;
		logic [31:0] x2a;
		logic [31:0] x1c;
		logic [31:0] m1;
		logic [31:0] m2;
		logic [31:0] b3;
		logic [31:0] x3b;
		logic [31:0] b4;
		logic [31:0] d;
		logic [31:0] b7;
		logic [31:0] p;
		logic [31:0] x1sq;
		logic [31:0] x2;
		logic [31:0] x1f;
	} ctx_t;

	function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] s);
		return 32'($signed(v) >>> s);
	endfunction

endpackage

// ----- src/bsc_div.sv -----
module bsc_div #(
	parameter int W  = 32,
	parameter int SB = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	input  logic [SB-1:0] side_in,
	output logic          out_valid,
	output logic [W-1:0]  quotient,
	output logic [SB-1:0] side_out
);
	logic          v_q   [W];
	logic [W-1:0]  rem_q [W];
	logic [W-1:0]  n_q   [W];
	logic [W-1:0]  d_q   [W];
	logic [SB-1:0] sb_q  [W];

	for (genvar i = 0; i < W; i++) begin : g_step
		logic          pv;
		logic [W-1:0]  prem, pn, pd;
		logic [SB-1:0] psb;
		logic [W:0]    tr;
		logic          ge;

		if (i == 0) begin : g_first
			assign pv   = in_valid;
			assign prem = '0;
			assign pn   = dividend;
			assign pd   = divisor;
			assign psb  = side_in;
		end else begin : g_next
			assign pv   = v_q[i-1];
			assign prem = rem_q[i-1];
			assign pn   = n_q[i-1];
			assign pd   = d_q[i-1];
			assign psb  = sb_q[i-1];
		end

		assign tr = {prem, pn[W-1]};
		assign ge = tr >= {1'b0, pd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? W'(tr - {1'b0, pd}) : tr[W-1:0];
				n_q[i]   <= {pn[W-2:0], ge};
				d_q[i]   <= pd;
				sb_q[i]  <= psb;
			end
		end
	end

	assign out_valid = v_q[W-1];
	assign quotient  = n_q[W-1];
	assign side_out  = sb_q[W-1];
endmodule

// ----- src/barometric_sensor_compensation.sv -----
// throughput: one word per cycle while the output is not stalled; two 32-stage one-bit-per-stage dividers set the depth
// the whole pipeline advances together and holds while the output word is stalled
// reset clears all valid bits and the coefficients, oversampling resets to mode 3
// with reset coefficients every word reports a fault
module barometric_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] raw_temperature,
	input  logic [23:0] raw_pressure_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] temperature_tenths,
	output logic signed [31:0] pressure_pa,
	output logic        fault
);
	import bsc_pkg::*;

	localparam int CW = $bits(ctx_t);

	logic [47:0] ac_first_q, ac_second_q;
	logic [31:0] b_pair_q, m_pair_q;
	logic [1:0]  oss_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14;
	ctx_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	ctx_t c_s11, c_s12, c_s13, c_s14;
	ctx_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13, n14;
	ctx_t c_next_out;
	logic [31:0] t_s1;
	logic [31:0] dva_n_s3, dva_d_s3;

	logic        va_out, vb_out;
	logic [31:0] qa, qb;
	logic [CW-1:0] sa_out, sb_out;
	ctx_t ca, cb;
	logic [31:0] dvb_n;
	logic [31:0] den, num, qs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_first_q  <= '0;
			ac_second_q <= '0;
			b_pair_q    <= '0;
			m_pair_q    <= '0;
			oss_q       <= 2'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AC_FIRST:  ac_first_q  <= cfg_data;
				REG_AC_SECOND: ac_second_q <= cfg_data;
				REG_B_PAIR:    b_pair_q    <= cfg_data[31:0];
				REG_M_PAIR:    m_pair_q    <= cfg_data[31:0];
				REG_OSS:       oss_q       <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign ac1 = 32'($signed(ac_first_q[47:32]));
	assign ac2 = 32'($signed(ac_first_q[31:16]));
	assign ac3 = 32'($signed(ac_first_q[15:0]));
	assign ac4 = {16'b0, ac_second_q[47:32]};
	assign ac5 = {16'b0, ac_second_q[31:16]};
	assign ac6 = {16'b0, ac_second_q[15:0]};
	assign b1  = 32'($signed(b_pair_q[31:16]));
	assign b2  = 32'($signed(b_pair_q[15:0]));
	assign mc  = 32'($signed(m_pair_q[31:16]));
	assign md  = 32'($signed(m_pair_q[15:0]));

	assign en       = !v_s14 || !out_stall;
	assign in_stall = !en;

	// temperature front end, which also aligns the raw pressure word
	always_comb begin
		n1    = '0;
		n1.up = 32'({8'b0, raw_pressure_bytes} >> (4'd8 - {2'b0, oss_q}));
	end

	always_comb begin
		n2    = c_s1;
		n2.x1 = sra32(t_s1 * ac5, 5'd15);
	end

	assign den = c_s2.x1 + md;
	assign num = mc << 11;
	always_comb begin
		n3       = c_s2;
		n3.fault = den == '0;
		n3.neg   = num[31] ^ den[31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= {16'b0, raw_temperature} - ac6;
			c_s1     <= n1;
			c_s2     <= n2;
			c_s3     <= n3;
			dva_n_s3 <= num[31] ? 32'(-num) : num;
			dva_d_s3 <= den[31] ? 32'(-den) : den;
		end
	end

	bsc_div #(.W(DW), .SB(CW)) u_div_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.dividend (dva_n_s3),
		.divisor  (dva_d_s3),
		.side_in  (c_s3),
		.out_valid(va_out),
		.quotient (qa),
		.side_out (sa_out)
	);
	assign ca = ctx_t'(sa_out);
	assign qs = ca.neg ? 32'(-qa) : qa;

	// pressure chain, which also rounds the temperature result
	always_comb begin
		n4    = ca;
		n4.b5 = ca.x1 + qs;
	end

	always_comb begin
		n5     = c_s4;
		n5.b6  = c_s4.b5 - C_B6_OFFSET;
		n5.tmp = sra32(c_s4.b5 + 32'd8, 5'd4);
	end

	always_comb begin
		n6     = c_s5;
		n6.sq  = sra32(c_s5.b6 * c_s5.b6, 5'd12);
		n6.x2a = sra32(ac2 * c_s5.b6, 5'd11);
		n6.x1c = sra32(ac3 * c_s5.b6, 5'd13);
	end

	always_comb begin
		n7    = c_s6;
		n7.m1 = sra32(b2 * c_s6.sq, 5'd11);
		n7.m2 = sra32(b1 * c_s6.sq, 5'd16);
	end

	always_comb begin
		n8     = c_s7;
		n8.b3  = sra32(32'((((ac1 << 2) + c_s7.m1 + c_s7.x2a) << oss_q) + 32'd2), 5'd2);
		n8.x3b = sra32(c_s7.x1c + c_s7.m2 + 32'd2, 5'd2);
	end

	always_comb begin
		n9       = c_s8;
		n9.b4    = (ac4 * (c_s8.x3b + C_B4_BIAS)) >> 15;
		n9.d     = c_s8.up - c_s8.b3;
		n9.fault = c_s8.fault || (n9.b4 == '0);
	end

	always_comb begin
		n10    = c_s9;
		n10.b7 = c_s9.d * (C_B7_SCALE >> oss_q);
	end

	always_comb begin
		n11      = c_s10;
		n11.post = c_s10.b7[31];
	end
	assign dvb_n = c_s10.b7[31] ? c_s10.b7 : (c_s10.b7 << 1);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4  <= n4;
			c_s5  <= n5;
			c_s6  <= n6;
			c_s7  <= n7;
			c_s8  <= n8;
			c_s9  <= n9;
			c_s10 <= n10;
		end
	end

	bsc_div #(.W(DW), .SB(CW)) u_div_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s10),
		.dividend (dvb_n),
		.divisor  (c_s10.b4),
		.side_in  (n11),
		.out_valid(vb_out),
		.quotient (qb),
		.side_out (sb_out)
	);
	assign cb = ctx_t'(sb_out);

	// pressure correction
	always_comb begin
		n12   = cb;
		n12.p = cb.post ? (qb << 1) : qb;
	end

	always_comb begin
		n13      = c_s11;
		n13.x1sq = sra32(c_s11.p, 5'd8) * sra32(c_s11.p, 5'd8);
		n13.x2   = sra32(C_P_LIN * c_s11.p, 5'd16);
	end

	always_comb begin
		n14     = c_s12;
		n14.x1f = sra32(c_s12.x1sq * C_P_SQ, 5'd16);
	end

	always_comb begin
		ctx_t r;
		r   = c_s13;
		r.p = c_s13.p + sra32(c_s13.x1f + c_s13.x2 + C_P_OFFSET, 5'd4);
		if (r.fault) begin
			r.p   = '0;
			r.tmp = '0;
		end
		c_next_out = r;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s11 <= n12;
			c_s12 <= n13;
			c_s13 <= n14;
			c_s14 <= c_next_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= va_out;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= vb_out;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	assign out_valid          = v_s14;
	assign temperature_tenths = $signed(c_s14.tmp);
	assign pressure_pa        = $signed(c_s14.p);
	assign fault              = c_s14.fault;

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> temperature_tenths == 0 && pressure_pa == 0)
		else $error("fault word carries nonzero results");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without an output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(temperature_tenths) && $stable(pressure_pa) && $stable(fault))
		else $error("pipeline moved while held");
endmodule

// ----- sim/tb_barometric_sensor_compensation.sv -----
`timescale 1ns / 1ps

module tb_barometric_sensor_compensation;
	import bsc_pkg::*;

	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] pres;
		logic        flt;
	} comp_word_t;

	localparam int LATENCY = 78;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] raw_temperature = '0;
	logic [23:0] raw_pressure_bytes = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic signed [31:0] temperature_tenths;
	logic signed [31:0] pressure_pa;
	logic        fault;

	logic [47:0] ac_first_q, ac_second_q;
	logic [31:0] b_pair_q, m_pair_q;
	logic [1:0]  oss_q;

	comp_word_t  expected_words[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          idle_count = 0;
	bit          calm = 1'b0;
	bit          timed_out = 1'b0;

	barometric_sensor_compensation dut (.*);

	always #5 clk = ~clk;

	function automatic logic [31:0] asr(input logic [31:0] v, input int s);
		return 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sx(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic comp_word_t compensate(input logic [15:0] ut_in, input logic [23:0] raw_p);
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, tmp;
		longint num, q;
		comp_word_t r;
		ac1 = sx(ac_first_q[47:32]); ac2 = sx(ac_first_q[31:16]); ac3 = sx(ac_first_q[15:0]);
		ac4 = {16'd0, ac_second_q[47:32]}; ac5 = {16'd0, ac_second_q[31:16]};
		ac6 = {16'd0, ac_second_q[15:0]};
		b1 = sx(b_pair_q[31:16]); b2 = sx(b_pair_q[15:0]);
		mc = sx(m_pair_q[31:16]); md = sx(m_pair_q[15:0]);
		ut = {16'd0, ut_in};
		up = {8'd0, raw_p} >> (8 - oss_q);
		r = '{temp: 32'd0, pres: 32'd0, flt: 1'b1};
		x1 = asr((ut - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0)
			return r;
		num = longint'($signed(mc << 11));
		q = num / longint'($signed(den));
		x2 = q[31:0];
		b5 = x1 + x2;
		tmp = asr(b5 + 32'd8, 4);
		b6 = b5 - 32'd4000;
		sq = asr(b6 * b6, 12);
		x1 = asr(b2 * sq, 11);
		x2 = asr(ac2 * b6, 11);
		x3 = x1 + x2;
		b3 = asr(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 2);
		x1 = asr(ac3 * b6, 13);
		x2 = asr(b1 * sq, 16);
		x3 = asr(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		b7 = (up - b3) * (32'd50000 >> oss_q);
		if (b4 == 0)
			return r;
		if (b7 < 32'h8000_0000)
			p = (b7 << 1) / b4;
		else
			p = (b7 / b4) << 1;
		x1 = asr(p, 8) * asr(p, 8);
		x1 = asr(x1 * 32'd3038, 16);
		x2 = asr((32'd0 - 32'd7357) * p, 16);
		p = p + asr(x1 + x2 + 32'd3791, 4);
		r = '{temp: tmp, pres: p, flt: 1'b0};
		return r;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 30);
	endfunction

	task automatic wait_drained();
		while (expected_words.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_AC_FIRST:  ac_first_q = val;
			REG_AC_SECOND: ac_second_q = val;
			REG_B_PAIR:    b_pair_q = val[31:0];
			REG_M_PAIR:    m_pair_q = val[31:0];
			REG_OSS:       oss_q = val[1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_cal(input logic [47:0] a1, input logic [47:0] a2, input logic [47:0] b,
			input logic [47:0] m, input logic [47:0] o);
		write_reg(REG_AC_FIRST, a1);
		write_reg(REG_AC_SECOND, a2);
		write_reg(REG_B_PAIR, b);
		write_reg(REG_M_PAIR, m);
		write_reg(REG_OSS, o);
	endtask

	// called just after a falling edge
	task automatic send_word(input logic [15:0] ut, input logic [23:0] rp);
		while (idle_now()) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		raw_temperature = ut;
		raw_pressure_bytes = rp;
		expected_words.push_back(compensate(ut, rp));
		do
			@(posedge clk);
		while (in_stall && !timed_out);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_word(16'($urandom), 24'($urandom));
	endtask

	task automatic set_datasheet_cal(input logic [1:0] o);
		set_cal({16'd408, 16'hFFB8, 16'hC6D1}, {16'd32741, 16'd32757, 16'd23153},
			{16'd0, 16'd6190, 16'd4}, {16'd0, 16'h8A7E, 16'd2868}, {46'd0, o});
	endtask

	task automatic test_reset_fault();
		send_word(16'd27898, 24'h5D_23_00);
		send_word(16'hFFFF, 24'hFFFFFF);
		send_word(16'h0000, 24'h000000);
		wait_drained();
	endtask

	task automatic test_datasheet_points();
		for (int o = 0; o < 4; o++) begin
			set_datasheet_cal(o[1:0]);
			send_word(16'd27898, 24'h5D_23_00);
			send_word(16'h0000, 24'h000000);
			send_word(16'hFFFF, 24'hFFFFFF);
			send_word(16'h8000, 24'h800000);
			wait_drained();
		end
	endtask

	task automatic test_zero_divisors();
		// temperature divisor zero: ac5 = 0, md = 0
		set_cal({16'd408, 16'hFFB8, 16'hC6D1}, {16'd32741, 16'd0, 16'd23153},
			{16'd0, 16'd6190, 16'd4}, {16'd0, 16'h8A7E, 16'd0}, 48'd1);
		send_word(16'd27898, 24'h5D_23_00);
		wait_drained();
		// pressure divisor zero: ac4 = 0
		set_cal({16'd408, 16'hFFB8, 16'hC6D1}, {16'd0, 16'd32757, 16'd23153},
			{16'd0, 16'd6190, 16'd4}, {16'd0, 16'h8A7E, 16'd2868}, 48'd2);
		send_word(16'd27898, 24'h5D_23_00);
		send_word(16'd100, 24'h123456);
		wait_drained();
		// extremes of every coefficient, upper bits ignored
		set_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_word(16'hFFFF, 24'hFFFFFF);
		send_word(16'h0001, 24'h000001);
		wait_drained();
		set_cal({16'h8000, 16'h8000, 16'h8000}, 48'h0001_0001_0001,
			{16'd0, 16'h8000, 16'h7FFF}, {16'd0, 16'h7FFF, 16'h8000}, 48'd0);
		send_word(16'h7FFF, 24'hABCDEF);
		send_word(16'h0000, 24'hFFFFFF);
		wait_drained();
	endtask

	task automatic test_random_cal();
		for (int k = 0; k < 12; k++) begin
			set_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
				{16'($urandom), $urandom}, {16'($urandom), $urandom},
				48'({$urandom, $urandom}));
			send_random(40);
			wait_drained();
		end
	endtask

	task automatic test_realistic_stream();
		for (int k = 0; k < 8; k++) begin
			set_datasheet_cal(2'($urandom));
			calm = (k == 3);
			for (int i = 0; i < 150; i++)
				send_word(16'($urandom_range(34000, 22000)), 24'($urandom_range(24'hB00000,
					24'h400000)));
			calm = 1'b0;
			wait_drained();
		end
	endtask

	always @(negedge clk)
		out_stall <= idle_now();

	always @(posedge clk) begin
		comp_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: t=%0d p=%0d f=%0b",
						temperature_tenths, pressure_pa, fault);
			end else begin
				e = expected_words.pop_front();
				if (temperature_tenths !== e.temp || pressure_pa !== e.pres
						|| fault !== e.flt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
							$signed(e.temp), $signed(e.pres), e.flt,
							temperature_tenths, pressure_pa, fault);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		ac_first_q = '0;
		ac_second_q = '0;
		b_pair_q = '0;
		m_pair_q = '0;
		oss_q = 2'd3;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_fault();
		test_datasheet_points();
		test_zero_divisors();
		test_random_cal();
		test_realistic_stream();
		if (expected_words.size() != 0)
			mismatches += expected_words.size();
		$display("covered reset faults, both zero divisors, coefficient extremes, all modes,");
		$display("%0d result words over random and realistic calibrations", results_seen);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
